// ===== src/rmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rmp_pkg;

  localparam int SEG_ENTRIES = 4096;
  localparam int CACHE_WAYS  = 16;
  localparam int COUNT_WIDTH = 32;

  localparam int SEG_AW  = $clog2(SEG_ENTRIES);
  localparam int WAY_W   = $clog2(CACHE_WAYS);
  localparam int GRP     = 4;
  localparam int NGRP    = (CACHE_WAYS + GRP - 1) / GRP;

  localparam int ADDR_W     = 52;
  localparam int FRAME_W    = 40;
  localparam int SEGIDX_W   = 12;
  localparam int SHIFT_W    = 6;
  localparam int WAYOUT_W   = 4;
  localparam int PAGE_BITS  = 12;
  localparam int PAGE_W     = ADDR_W - PAGE_BITS;
  localparam int ENTRY_LOG2 = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_W       = 104;
  localparam int OUT_W      = 112;

  localparam logic [ADDR_W-1:0]  SEG_ADDR_MASK  = 52'hffffffff00000;
  localparam logic [ADDR_W-1:0]  BOOKKEEP_BYTES = 52'h4000;
  localparam logic [SHIFT_W-1:0] SHIFT_MIN      = 6'd12;
  localparam logic [SHIFT_W-1:0] SPAN_MAX       = 6'd40;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET    = 6'd36;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_BASE = 2'd0,
    CFG_SEG_MODE   = 2'd1,
    CFG_SEG_SHIFT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_MATCH = 4'b0100,
    S_PICK  = 4'b1000
  } state_t;

  typedef struct packed {
    logic cap;
    logic commit;
  } lfu_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
  } lfu_res_t;

endpackage

`default_nettype wire

// ===== src/rmp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/rmp_lfu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmp_lfu (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rmp_pkg::lfu_ctl_t             ctl,
  input  wire logic [rmp_pkg::PAGE_W-1:0]    page,
  output rmp_pkg::lfu_res_t                  res
);

  localparam int NPAD = rmp_pkg::NGRP * rmp_pkg::GRP;

  logic [rmp_pkg::PAGE_W-1:0]      tag_r [rmp_pkg::CACHE_WAYS];
  logic [rmp_pkg::COUNT_WIDTH-1:0] cnt_r [rmp_pkg::CACHE_WAYS];
  logic [rmp_pkg::CACHE_WAYS-1:0]  valid_r;

  logic [rmp_pkg::PAGE_W-1:0]      page_r;
  logic [rmp_pkg::CACHE_WAYS-1:0]  hitvec_r;
  logic [rmp_pkg::COUNT_WIDTH-1:0] gmin_r [rmp_pkg::NGRP];
  logic [rmp_pkg::WAY_W-1:0]       gidx_r [rmp_pkg::NGRP];

  logic [rmp_pkg::COUNT_WIDTH-1:0] eff    [NPAD];
  logic [rmp_pkg::CACHE_WAYS-1:0]  hitvec_nxt;
  logic [rmp_pkg::COUNT_WIDTH-1:0] gmin_nxt [rmp_pkg::NGRP];
  logic [rmp_pkg::WAY_W-1:0]       gidx_nxt [rmp_pkg::NGRP];

  logic [rmp_pkg::COUNT_WIDTH-1:0] vmin;
  logic [rmp_pkg::WAY_W-1:0]       victim;
  logic [rmp_pkg::WAY_W-1:0]       hit_way;
  logic                            any_hit;

  always_comb begin
    for (int i = 0; i < NPAD; i++) begin
      eff[i] = '1;
    end
    for (int i = 0; i < rmp_pkg::CACHE_WAYS; i++) begin
      eff[i] = valid_r[i] ? cnt_r[i] : '0;
      hitvec_nxt[i] = valid_r[i] && (tag_r[i] == page);
    end
    for (int g = 0; g < rmp_pkg::NGRP; g++) begin
      gmin_nxt[g] = eff[g * rmp_pkg::GRP];
      gidx_nxt[g] = rmp_pkg::WAY_W'(g * rmp_pkg::GRP);
      for (int k = 1; k < rmp_pkg::GRP; k++) begin
        if (eff[g * rmp_pkg::GRP + k] < gmin_nxt[g]) begin
          gmin_nxt[g] = eff[g * rmp_pkg::GRP + k];
          gidx_nxt[g] = rmp_pkg::WAY_W'(g * rmp_pkg::GRP + k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      page_r   <= page;
      hitvec_r <= hitvec_nxt;
      for (int g = 0; g < rmp_pkg::NGRP; g++) begin
        gmin_r[g] <= gmin_nxt[g];
        gidx_r[g] <= gidx_nxt[g];
      end
    end
  end

  always_comb begin
    vmin   = gmin_r[0];
    victim = gidx_r[0];
    for (int g = 1; g < rmp_pkg::NGRP; g++) begin
      if (gmin_r[g] < vmin) begin
        vmin   = gmin_r[g];
        victim = gidx_r[g];
      end
    end
    any_hit = |hitvec_r;
    hit_way = '0;
    for (int i = rmp_pkg::CACHE_WAYS - 1; i >= 0; i--) begin
      if (hitvec_r[i]) begin
        hit_way = rmp_pkg::WAY_W'(i);
      end
    end
  end

  assign res.hit = any_hit;
  assign res.way = any_hit ? hit_way : victim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < rmp_pkg::CACHE_WAYS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (ctl.commit) begin
      if (any_hit) begin
        if (cnt_r[hit_way] != '1) begin
          cnt_r[hit_way] <= cnt_r[hit_way] + 1'b1;
        end
      end else begin
        valid_r[victim] <= 1'b1;
        cnt_r[victim]   <= rmp_pkg::COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && !any_hit) begin
      tag_r[victim] <= page_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/rmp_entry_locate_lfu_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Fields (low bit up)                                  | Per transfer
// in_      | in  | tdata: frame_number, seg_index, seg_word; tuser: cmd | one command
// out_     | out | tdata: entry_address, segment_number, range_error,   | one per lookup
//          |     |        hit, way_index, fetch_page                    |
// cfg_     | in  | index 0 table_base, 1 segmented_mode, 2 segment_shift| one register
//
// A load writes the segment store when accepted. A lookup steps through segment store
// read, address add, way compare with partial minimum, then final victim pick and count
// update; a range error skips the way compare. After reset a clear pass writes 4096
// segment store words, one a cycle, with in_tready low. A lookup result waits in the
// output register; a stalled output holds the final step until the register frees.
module rmp_entry_locate_lfu_cache (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [rmp_pkg::IN_W-1:0]        in_tdata,   // frame_number, seg_index, seg_word
  input  wire logic [0:0]                      in_tuser,   // cmd
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [rmp_pkg::OUT_W-1:0]            out_tdata,  // entry_address, segment_number,
                                                           // range_error, hit, way_index,
                                                           // fetch_page
  input  wire logic                            cfg_we,
  input  wire logic [rmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rmp_pkg::ADDR_W-1:0]      cfg_wdata
);

  logic [rmp_pkg::FRAME_W-1:0]  in_frame;
  logic [rmp_pkg::SEGIDX_W-1:0] in_seg_index;
  logic [rmp_pkg::ADDR_W-1:0]   in_seg_word;
  logic                         in_cmd;

  assign in_frame     = in_tdata[rmp_pkg::FRAME_W-1:0];
  assign in_seg_index = in_tdata[rmp_pkg::FRAME_W+rmp_pkg::SEGIDX_W-1:rmp_pkg::FRAME_W];
  assign in_seg_word  = in_tdata[rmp_pkg::IN_W-1:rmp_pkg::FRAME_W+rmp_pkg::SEGIDX_W];
  assign in_cmd       = in_tuser[0];

  logic [rmp_pkg::ADDR_W-1:0]  base_r;
  logic                        seg_mode_r;
  logic [rmp_pkg::SHIFT_W-1:0] shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      seg_mode_r <= 1'b0;
      shift_r    <= rmp_pkg::SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (rmp_pkg::cfg_idx_t'(cfg_index))
        rmp_pkg::CFG_TABLE_BASE: base_r     <= cfg_wdata;
        rmp_pkg::CFG_SEG_MODE:   seg_mode_r <= cfg_wdata[0];
        rmp_pkg::CFG_SEG_SHIFT:  shift_r    <= cfg_wdata[rmp_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  rmp_pkg::state_t state_r, state_nxt;

  logic                       clr_busy_r;
  logic [rmp_pkg::SEG_AW-1:0] clr_addr_r;

  logic in_xfer, look_xfer, load_xfer, load_ok;
  logic out_free, out_load;

  assign in_tready = (state_r == rmp_pkg::S_IDLE) && !clr_busy_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign look_xfer = in_xfer && (in_cmd == rmp_pkg::CMD_LOOKUP);
  assign load_xfer = in_xfer && (in_cmd == rmp_pkg::CMD_LOAD);
  assign load_ok   = 32'(in_seg_index) < 32'(rmp_pkg::SEG_ENTRIES);
  assign out_free  = !out_tvalid || out_tready;
  assign out_load  = (state_r == rmp_pkg::S_PICK) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == rmp_pkg::SEG_AW'(rmp_pkg::SEG_ENTRIES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  logic [rmp_pkg::SHIFT_W-1:0] span;
  logic [rmp_pkg::FRAME_W-1:0] segno_w, off_w;

  always_comb begin
    if (shift_r < rmp_pkg::SHIFT_MIN) begin
      span = '0;
    end else if (shift_r - rmp_pkg::SHIFT_MIN > rmp_pkg::SPAN_MAX) begin
      span = rmp_pkg::SPAN_MAX;
    end else begin
      span = shift_r - rmp_pkg::SHIFT_MIN;
    end
    segno_w = in_frame >> span;
    off_w   = in_frame & ((rmp_pkg::FRAME_W'(1) << span) - rmp_pkg::FRAME_W'(1));
  end

  logic                        ram_we;
  logic [rmp_pkg::SEG_AW-1:0]  ram_waddr;
  logic [rmp_pkg::ADDR_W-1:0]  ram_wdata;
  logic [rmp_pkg::ADDR_W-1:0]  ram_rdata;

  assign ram_we    = clr_busy_r || (load_xfer && load_ok);
  assign ram_waddr = clr_busy_r ? clr_addr_r : rmp_pkg::SEG_AW'(in_seg_index);
  assign ram_wdata = clr_busy_r ? '0 : in_seg_word;

  rmp_ram #(
    .WIDTH (rmp_pkg::ADDR_W),
    .DEPTH (rmp_pkg::SEG_ENTRIES)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (look_xfer),
    .raddr (rmp_pkg::SEG_AW'(segno_w)),
    .rdata (ram_rdata)
  );

  logic [rmp_pkg::FRAME_W-1:0]  frame_r, off_r;
  logic [rmp_pkg::SEGIDX_W-1:0] segno_r;
  logic                         oor_r;

  always_ff @(posedge clk) begin
    if (look_xfer) begin
      frame_r <= in_frame;
      off_r   <= off_w;
      segno_r <= segno_w[rmp_pkg::SEGIDX_W-1:0];
      oor_r   <= segno_w >= rmp_pkg::FRAME_W'(rmp_pkg::SEG_ENTRIES);
    end
  end

  logic [rmp_pkg::ADDR_W-1:0] op_a, op_b, addr_nxt, addr_r;
  logic                       err_nxt, err_r;

  always_comb begin
    err_nxt = seg_mode_r && (oor_r || (ram_rdata == '0));
    op_a    = seg_mode_r ? (ram_rdata & rmp_pkg::SEG_ADDR_MASK)
                         : (base_r + rmp_pkg::BOOKKEEP_BYTES);
    op_b    = rmp_pkg::ADDR_W'(seg_mode_r ? off_r : frame_r) << rmp_pkg::ENTRY_LOG2;
    addr_nxt = op_a + op_b;
  end

  always_ff @(posedge clk) begin
    if (state_r == rmp_pkg::S_READ) begin
      addr_r <= addr_nxt;
      err_r  <= err_nxt;
    end
  end

  rmp_pkg::lfu_ctl_t lfu_ctl;
  rmp_pkg::lfu_res_t lfu_res;

  assign lfu_ctl.cap    = (state_r == rmp_pkg::S_MATCH);
  assign lfu_ctl.commit = out_load && !err_r;

  rmp_lfu u_lfu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lfu_ctl),
    .page  (addr_r[rmp_pkg::ADDR_W-1:rmp_pkg::PAGE_BITS]),
    .res   (lfu_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmp_pkg::S_IDLE:  if (look_xfer) state_nxt = rmp_pkg::S_READ;
      rmp_pkg::S_READ:  state_nxt = err_nxt ? rmp_pkg::S_PICK : rmp_pkg::S_MATCH;
      rmp_pkg::S_MATCH: state_nxt = rmp_pkg::S_PICK;
      rmp_pkg::S_PICK:  if (out_free) state_nxt = rmp_pkg::S_IDLE;
      default:          state_nxt = rmp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  logic                         out_valid_r;
  logic [rmp_pkg::OUT_W-1:0]    out_data_r, out_data_nxt;
  logic [rmp_pkg::SEGIDX_W-1:0] seg_out;

  always_comb begin
    seg_out = seg_mode_r ? segno_r : '0;
    if (err_r) begin
      out_data_nxt = {2'b0, rmp_pkg::PAGE_W'(0), rmp_pkg::WAYOUT_W'(0), 1'b0, 1'b1,
                      segno_r, rmp_pkg::ADDR_W'(0)};
    end else begin
      out_data_nxt = {2'b0, addr_r[rmp_pkg::ADDR_W-1:rmp_pkg::PAGE_BITS],
                      rmp_pkg::WAYOUT_W'(lfu_res.way), lfu_res.hit, 1'b0,
                      seg_out, addr_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_pick_emits: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid)
    else $error("finished lookup did not reach the output register");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[64]) |->
      (out_data_r[51:0] == '0) && !out_data_r[65] && (out_data_r[109:70] == '0))
    else $error("range error result carries address or cache fields");

  a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(clr_busy_r) && !clr_busy_r) |->
      ($past(clr_addr_r) == rmp_pkg::SEG_AW'(rmp_pkg::SEG_ENTRIES - 1)))
    else $error("clear pass ended before the last segment word");

  a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
    look_xfer |=> (state_r == rmp_pkg::S_READ))
    else $error("accepted lookup did not start the segment read");

endmodule

`default_nettype wire

// ===== sim/tb_rmp_entry_locate_lfu_cache.sv =====
`timescale 1ns / 1ps

module tb_rmp_entry_locate_lfu_cache;
  import rmp_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int HOLD_CYCLES = 640;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [SEGIDX_W-1:0] segno;
    logic                err;
    logic                hit;
    logic [WAYOUT_W-1:0] way;
    logic [PAGE_W-1:0]   page;
  } entry_result_t;

  class entry_locator;
    logic [ADDR_W-1:0]      seg_words [SEG_ENTRIES];
    logic [PAGE_W-1:0]      page_tags [CACHE_WAYS];
    bit                     page_live [CACHE_WAYS];
    logic [COUNT_WIDTH-1:0] use_count [CACHE_WAYS];
    logic [ADDR_W-1:0]      base_reg;
    bit                     seg_mode;
    logic [SHIFT_W-1:0]     shift_reg;
    entry_result_t          awaited [$];
    int                     fail_count;

    function new();
      foreach (seg_words[i]) seg_words[i] = '0;
      foreach (page_tags[i]) begin
        page_tags[i] = '0;
        page_live[i] = 1'b0;
        use_count[i] = '0;
      end
      base_reg   = '0;
      seg_mode   = 1'b0;
      shift_reg  = SHIFT_RESET;
      fail_count = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [ADDR_W-1:0] v);
      case (idx)
        CFG_TABLE_BASE: base_reg = v;
        CFG_SEG_MODE:   seg_mode = v[0];
        CFG_SEG_SHIFT:  shift_reg = v[SHIFT_W-1:0];
        default: ;
      endcase
    endfunction

    function void accept_command(logic cmd, logic [FRAME_W-1:0] frame,
                                 logic [SEGIDX_W-1:0] idx, logic [ADDR_W-1:0] word);
      entry_result_t          r;
      logic [63:0]            segno;
      logic [63:0]            offset;
      logic [63:0]            sum;
      int                     span;
      int                     victim;
      logic [COUNT_WIDTH-1:0] least;
      logic [COUNT_WIDTH-1:0] c;
      if (cmd == CMD_LOAD) begin
        seg_words[idx] = word;
        return;
      end
      r = '0;
      if (seg_mode) begin
        span = (shift_reg < SHIFT_MIN) ? 0 : int'(shift_reg) - int'(SHIFT_MIN);
        if (span > int'(SPAN_MAX)) span = int'(SPAN_MAX);
        segno = 64'(frame) >> span;
        r.segno = segno[SEGIDX_W-1:0];
        if (segno >= SEG_ENTRIES || seg_words[segno[SEG_AW-1:0]] == '0) begin
          r.err = 1'b1;
          awaited.push_back(r);
          return;
        end
        offset = 64'(frame) & ((64'd1 << span) - 64'd1);
        sum = 64'(seg_words[segno[SEG_AW-1:0]] & SEG_ADDR_MASK) + (offset << ENTRY_LOG2);
      end else begin
        sum = 64'(base_reg) + 64'(BOOKKEEP_BYTES) + (64'(frame) << ENTRY_LOG2);
      end
      r.addr = sum[ADDR_W-1:0];
      r.page = r.addr[ADDR_W-1:PAGE_BITS];
      victim = 0;
      least = page_live[0] ? use_count[0] : '0;
      for (int i = 0; i < CACHE_WAYS; i++) begin
        c = page_live[i] ? use_count[i] : '0;
        if (page_live[i] && page_tags[i] == r.page) begin
          if (use_count[i] != '1) use_count[i] = use_count[i] + 1'b1;
          r.hit = 1'b1;
          r.way = WAYOUT_W'(i);
          awaited.push_back(r);
          return;
        end
        if (c < least) begin
          least  = c;
          victim = i;
        end
      end
      page_tags[victim] = r.page;
      page_live[victim] = 1'b1;
      use_count[victim] = 1;
      r.way = WAYOUT_W'(victim);
      awaited.push_back(r);
    endfunction

    function void compare_entry(logic [OUT_W-1:0] data);
      entry_result_t got;
      entry_result_t want;
      got.addr  = data[51:0];
      got.segno = data[63:52];
      got.err   = data[64];
      got.hit   = data[65];
      got.way   = data[69:66];
      got.page  = data[109:70];
      if (awaited.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected entry result: %h", data);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("entry mismatch: want addr=%h seg=%h err=%b hit=%b way=%0d page=%h",
                   want.addr, want.segno, want.err, want.hit, want.way, want.page);
          $display("                got  addr=%h seg=%h err=%b hit=%b way=%0d page=%h",
                   got.addr, got.segno, got.err, got.hit, got.way, got.page);
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic [0:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_we = 1'b0;
  cfg_idx_t             cfg_index = CFG_TABLE_BASE;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  entry_locator         model;
  int                   burst_left = 0;
  int                   span_now = 24;
  logic [FRAME_W-1:0]   hot [$];
  int                   live_segs [$];
  bit                   hold_req = 1'b0;
  int                   hold_left = 0;
  logic [1:0]           rx_mode = 2'd0;
  int                   rx_left = 0;
  logic [7:0]           rx_tick = '0;
  int unsigned          cycle_count = 0;

  rmp_entry_locate_lfu_cache u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] rand52();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[ADDR_W-1:0];
  endfunction

  function automatic logic [FRAME_W-1:0] rand40();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[FRAME_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] live_word();
    logic [ADDR_W-1:0] w;
    if ($urandom_range(0, 3) == 0) return ADDR_W'($urandom_range(1, 20'hFFFFF));
    w = rand52();
    return (w == '0) ? ADDR_W'(1) : w;
  endfunction

  function automatic logic [FRAME_W-1:0] seg_frame(int s, logic [FRAME_W-1:0] off);
    logic [79:0] t;
    t = (80'(s) << span_now) | (80'(off) & ((80'd1 << span_now) - 80'd1));
    return t[FRAME_W-1:0];
  endfunction

  task automatic put_item(logic cmd, logic [FRAME_W-1:0] frame,
                          logic [SEGIDX_W-1:0] idx, logic [ADDR_W-1:0] word);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {word, idx, frame};
    do @(posedge clk); while (!in_tready);
    model.accept_command(cmd, frame, idx, word);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 12);
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic lookup(logic [FRAME_W-1:0] frame);
    put_item(CMD_LOOKUP, frame, SEGIDX_W'($urandom), rand52());
  endtask

  task automatic load(int idx, logic [ADDR_W-1:0] word);
    put_item(CMD_LOAD, rand40(), SEGIDX_W'(idx), word);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [ADDR_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    model.write_reg(idx, v);
  endtask

  task automatic configure(logic [ADDR_W-1:0] base, logic mode, logic [SHIFT_W-1:0] shift);
    in_tvalid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    // let a trailing load settle
    repeat (10) @(posedge clk);
    write_reg(CFG_TABLE_BASE, base);
    write_reg(CFG_SEG_MODE, ADDR_W'(mode));
    write_reg(CFG_SEG_SHIFT, ADDR_W'(shift));
    cfg_we <= 1'b0;
    span_now = (shift < SHIFT_MIN) ? 0 : int'(shift) - int'(SHIFT_MIN);
    if (span_now > int'(SPAN_MAX)) span_now = int'(SPAN_MAX);
  endtask

  task automatic directed_checks();
    lookup('0);
    lookup('0);
    lookup('1);
    lookup('1);
    load(0, '1);
    load(SEG_ENTRIES - 1, ADDR_W'(1));
    configure('1, 1'b0, SHIFT_RESET);
    lookup('0);
    configure('0, 1'b1, SHIFT_RESET);
    lookup('0);
    lookup({4'h0, 12'hFFF, 24'hFFFFFF});
    lookup(FRAME_W'(5) << 24);
    lookup(FRAME_W'(SEG_ENTRIES) << 24);
    lookup('1);
    load(0, '0);
    lookup('0);
    load(0, 52'h123456789A);
    configure('0, 1'b1, 6'd0);
    lookup(FRAME_W'(SEG_ENTRIES - 1));
    lookup(FRAME_W'(SEG_ENTRIES - 1));
    lookup(FRAME_W'(SEG_ENTRIES));
    configure('0, 1'b1, 6'd63);
    lookup('1);
    lookup('0);
  endtask

  task automatic flat_phase(int n, logic [ADDR_W-1:0] base, bit squeeze);
    int k;
    int r;
    configure(base, 1'b0, SHIFT_W'($urandom_range(0, 63)));
    if (squeeze) hold_req <= 1'b1;
    hot.delete();
    k = $urandom_range(4, 24);
    repeat (k) hot.push_back(rand40() & ~FRAME_W'(8'hFF));
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 75) lookup(hot[$urandom_range(0, hot.size() - 1)] + $urandom_range(0, 255));
      else if (r < 87) lookup(rand40());
      else if (r < 94) load($urandom_range(0, SEG_ENTRIES - 1), rand52());
      else if (r < 97) lookup(FRAME_W'($urandom_range(0, 300)));
      else lookup('1 - FRAME_W'($urandom_range(0, 300)));
    end
  endtask

  task automatic segment_phase(int n, logic [SHIFT_W-1:0] shift, bit squeeze);
    int k;
    int r;
    int s;
    int top_seg;
    logic [ADDR_W-1:0] w;
    configure(rand52(), 1'b1, shift);
    if (squeeze) hold_req <= 1'b1;
    top_seg = (span_now >= 28) ? (1 << (40 - span_now)) - 1 : SEG_ENTRIES - 1;
    live_segs.delete();
    hot.delete();
    k = $urandom_range(3, 10);
    repeat (k) begin
      s = $urandom_range(0, top_seg);
      live_segs.push_back(s);
      load(s, live_word());
    end
    k = $urandom_range(4, 20);
    repeat (k) hot.push_back(rand40() & ~FRAME_W'(8'hFF));
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        lookup(seg_frame(live_segs[$urandom_range(0, live_segs.size() - 1)],
                         hot[$urandom_range(0, hot.size() - 1)] + $urandom_range(0, 255)));
      end else if (r < 78) begin
        s = $urandom_range(0, 1) ? live_segs[$urandom_range(0, live_segs.size() - 1)]
                                 : $urandom_range(0, top_seg);
        w = ($urandom_range(0, 5) == 0) ? '0 : live_word();
        load(s, w);
        if (w != '0) live_segs.push_back(s);
      end else if (r < 86) begin
        lookup(seg_frame($urandom_range(0, top_seg), rand40()));
      end else if (r < 93) begin
        lookup(rand40());
      end else begin
        lookup(seg_frame(live_segs[$urandom_range(0, live_segs.size() - 1)], rand40()));
      end
    end
  endtask

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req) begin
      hold_req   <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= 2'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= 1'($urandom_range(0, 1));
        2'd2: out_tready <= ($urandom_range(0, 7) != 0);
        default: out_tready <= (rx_tick[1:0] == 2'b00);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) model.compare_entry(out_tdata);
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    model = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    directed_checks();
    flat_phase(200, '1, 1'b1);
    flat_phase(200, rand52(), 1'b0);
    segment_phase(220, 6'd36, 1'b0);
    segment_phase(180, 6'd12, 1'b0);
    segment_phase(150, 6'd0, 1'b1);
    segment_phase(180, 6'd63, 1'b0);
    segment_phase(150, 6'd52, 1'b0);
    segment_phase(200, 6'd20, 1'b1);
    segment_phase(150, SHIFT_W'($urandom_range(13, 51)), 1'b0);
    in_tvalid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (model.fail_count == 0 && model.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
